// ----- hw/rtl/rth_pkg.sv -----
// shared types and constants for the ray-triangle hit test
package rth_pkg;

  localparam int THR_WIDTH = 41;
  localparam int CFG_IDX_W = 3;
  localparam int REASON_W  = 3;

  localparam logic [THR_WIDTH-1:0] DET_THR_RESET = 41'd1074;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DET_THR  = 3'd6;

  typedef enum logic [REASON_W-1:0] {
    REASON_HIT      = 3'd0,
    REASON_PARALLEL = 3'd1,
    REASON_U_OUT    = 3'd2,
    REASON_V_OUT    = 3'd3,
    REASON_BEHIND   = 3'd4
  } reason_t;

  // axis order for cross products: r[i] = a[next]*b[prev] - a[prev]*b[next]
  localparam int NEXT_AXIS [3] = '{1, 2, 0};
  localparam int PREV_AXIS [3] = '{2, 0, 1};

endpackage

// ----- hw/rtl/rth_if.sv -----
// valid/ready channels for triangles in and hit results out

interface rth_in_if #(
  parameter int COORD_WIDTH = 20
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] first_z;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;
  logic signed [COORD_WIDTH-1:0] second_z;
  logic signed [COORD_WIDTH-1:0] third_x;
  logic signed [COORD_WIDTH-1:0] third_y;
  logic signed [COORD_WIDTH-1:0] third_z;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z,
    output ready
  );
endinterface

interface rth_out_if
  import rth_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                hit;
  logic [REASON_W-1:0] reject_reason;

  modport source (output valid, hit, reject_reason, input ready);
  modport sink (input valid, hit, reject_reason, output ready);
endinterface

// ----- hw/rtl/rth_geom.sv -----
// edge vectors and the two cross products, three pipeline stages
module rth_geom
  import rth_pkg::*;
#(
  parameter int CW = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  rth_in_if.sink                 in_tri,
  input  logic signed [CW-1:0]   origin [3],
  input  logic signed [CW-1:0]   dir [3],
  output logic                   g_valid,
  input  logic                   g_ready,
  output logic signed [CW:0]     e1 [3],
  output logic signed [CW:0]     e2 [3],
  output logic signed [CW:0]     s [3],
  output logic signed [2*CW+2:0] p [3],
  output logic signed [2*CW+2:0] q [3]
);

  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int CPW = 2 * DW + 1;

  logic en_a, en_b, en_c;
  logic va_r, vb_r, vc_r;

  logic signed [CW-1:0] vt1 [3];
  logic signed [CW-1:0] vt2 [3];
  logic signed [CW-1:0] vt3 [3];
  logic signed [DW-1:0] dx [3];

  logic signed [DW-1:0] e1_nxt [3];
  logic signed [DW-1:0] e2_nxt [3];
  logic signed [DW-1:0] s_nxt [3];
  logic signed [DW-1:0] e1a_r [3];
  logic signed [DW-1:0] e2a_r [3];
  logic signed [DW-1:0] sa_r [3];

  logic signed [PW-1:0] mpa_nxt [3];
  logic signed [PW-1:0] mpb_nxt [3];
  logic signed [PW-1:0] mqa_nxt [3];
  logic signed [PW-1:0] mqb_nxt [3];
  logic signed [PW-1:0] mpa_r [3];
  logic signed [PW-1:0] mpb_r [3];
  logic signed [PW-1:0] mqa_r [3];
  logic signed [PW-1:0] mqb_r [3];
  logic signed [DW-1:0] e1b_r [3];
  logic signed [DW-1:0] e2b_r [3];
  logic signed [DW-1:0] sb_r [3];

  logic signed [CPW-1:0] p_nxt [3];
  logic signed [CPW-1:0] q_nxt [3];
  logic signed [CPW-1:0] p_r [3];
  logic signed [CPW-1:0] q_r [3];
  logic signed [DW-1:0]  e1c_r [3];
  logic signed [DW-1:0]  e2c_r [3];
  logic signed [DW-1:0]  sc_r [3];

  assign en_c = ~vc_r | g_ready;
  assign en_b = ~vb_r | en_c;
  assign en_a = ~va_r | en_b;
  assign in_tri.ready = en_a;
  assign g_valid = vc_r;

  always_comb begin
    vt1 = '{in_tri.first_x, in_tri.first_y, in_tri.first_z};
    vt2 = '{in_tri.second_x, in_tri.second_y, in_tri.second_z};
    vt3 = '{in_tri.third_x, in_tri.third_y, in_tri.third_z};
    for (int i = 0; i < 3; i++) begin
      e1_nxt[i] = DW'(vt2[i]) - DW'(vt1[i]);
      e2_nxt[i] = DW'(vt3[i]) - DW'(vt1[i]);
      s_nxt[i]  = DW'(origin[i]) - DW'(vt1[i]);
      dx[i]     = DW'(dir[i]);
    end
  end

  // cross product terms: P = D x E2, Q = S x E1
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mpa_nxt[i] = PW'(dx[NEXT_AXIS[i]]) * PW'(e2a_r[PREV_AXIS[i]]);
      mpb_nxt[i] = PW'(dx[PREV_AXIS[i]]) * PW'(e2a_r[NEXT_AXIS[i]]);
      mqa_nxt[i] = PW'(sa_r[NEXT_AXIS[i]]) * PW'(e1a_r[PREV_AXIS[i]]);
      mqb_nxt[i] = PW'(sa_r[PREV_AXIS[i]]) * PW'(e1a_r[NEXT_AXIS[i]]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_nxt[i] = CPW'(mpa_r[i]) - CPW'(mpb_r[i]);
      q_nxt[i] = CPW'(mqa_r[i]) - CPW'(mqb_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_tri.valid;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      e1a_r <= e1_nxt;
      e2a_r <= e2_nxt;
      sa_r  <= s_nxt;
    end
    if (en_b) begin
      mpa_r <= mpa_nxt;
      mpb_r <= mpb_nxt;
      mqa_r <= mqa_nxt;
      mqb_r <= mqb_nxt;
      e1b_r <= e1a_r;
      e2b_r <= e2a_r;
      sb_r  <= sa_r;
    end
    if (en_c) begin
      p_r   <= p_nxt;
      q_r   <= q_nxt;
      e1c_r <= e1b_r;
      e2c_r <= e2b_r;
      sc_r  <= sb_r;
    end
  end

  assign e1 = e1c_r;
  assign e2 = e2c_r;
  assign s  = sc_r;
  assign p  = p_r;
  assign q  = q_r;

endmodule

// ----- hw/rtl/rth_dot.sv -----
// determinant and the three numerators as split-multiply dot products, five stages
module rth_dot
  import rth_pkg::*;
#(
  parameter int CW = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   g_valid,
  output logic                   g_ready,
  input  logic signed [CW-1:0]   dir [3],
  input  logic signed [CW:0]     e1 [3],
  input  logic signed [CW:0]     e2 [3],
  input  logic signed [CW:0]     s [3],
  input  logic signed [2*CW+2:0] p [3],
  input  logic signed [2*CW+2:0] q [3],
  output logic                   d_valid,
  input  logic                   d_ready,
  output logic signed [3*CW+5:0] det,
  output logic signed [3*CW+5:0] nu,
  output logic signed [3*CW+5:0] nv,
  output logic signed [3*CW+5:0] nt
);

  localparam int DW    = CW + 1;
  localparam int CPW   = 2 * DW + 1;
  localparam int LO    = (CPW + 1) / 2;
  localparam int HI    = CPW - LO;
  localparam int PLW   = DW + LO + 1;
  localparam int PHW   = DW + HI;
  localparam int DOTW  = 3 * DW + 3;
  localparam int NTERM = 12;
  localparam int NSTG  = 5;

  logic [NSTG-1:0] en;
  logic [NSTG-1:0] v_r;

  logic signed [DW-1:0]  a_op [NTERM];
  logic signed [CPW-1:0] b_op [NTERM];

  logic signed [PLW-1:0]  lo_nxt [NTERM];
  logic signed [PHW-1:0]  hi_nxt [NTERM];
  logic signed [PLW-1:0]  lo_r [NTERM];
  logic signed [PHW-1:0]  hi_r [NTERM];
  logic signed [DOTW-1:0] term_nxt [NTERM];
  logic signed [DOTW-1:0] term_r [NTERM];
  logic signed [DOTW-1:0] pair_nxt [4];
  logic signed [DOTW-1:0] pair_r [4];
  logic signed [DOTW-1:0] third_r [4];
  logic signed [DOTW-1:0] sum_nxt [4];
  logic signed [DOTW-1:0] sum_r [4];
  logic signed [DOTW-1:0] fix_nxt [4];
  logic signed [DOTW-1:0] fix_r [4];

  always_comb begin
    en[NSTG-1] = ~v_r[NSTG-1] | d_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = ~v_r[k] | en[k+1];
    end
  end

  assign g_ready = en[0];
  assign d_valid = v_r[NSTG-1];

  // term t*3+i: det = E1.P, U = S.P, V = D.Q, T = E2.Q
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_op[i]     = e1[i];
      b_op[i]     = p[i];
      a_op[3 + i] = s[i];
      b_op[3 + i] = p[i];
      a_op[6 + i] = DW'(dir[i]);
      b_op[6 + i] = q[i];
      a_op[9 + i] = e2[i];
      b_op[9 + i] = q[i];
    end
  end

  // the wide operand is split into an unsigned low half and a signed high half
  always_comb begin
    for (int t = 0; t < NTERM; t++) begin
      lo_nxt[t] = PLW'(a_op[t]) * PLW'($signed({1'b0, b_op[t][LO-1:0]}));
      hi_nxt[t] = PHW'(a_op[t]) * PHW'($signed(b_op[t][CPW-1:LO]));
    end
  end

  always_comb begin
    for (int t = 0; t < NTERM; t++) begin
      term_nxt[t] = (DOTW'(hi_r[t]) <<< LO) + DOTW'(lo_r[t]);
    end
  end

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      pair_nxt[d] = term_r[3*d] + term_r[3*d + 1];
      sum_nxt[d]  = pair_r[d] + third_r[d];
    end
  end

  // make det non-negative, flipping the numerators with it
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      fix_nxt[d] = sum_r[0][DOTW-1] ? -sum_r[d] : sum_r[d];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= g_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (en[1]) term_r <= term_nxt;
    if (en[2]) begin
      pair_r <= pair_nxt;
      for (int d = 0; d < 4; d++) begin
        third_r[d] <= term_r[3*d + 2];
      end
    end
    if (en[3]) sum_r <= sum_nxt;
    if (en[4]) fix_r <= fix_nxt;
  end

  assign det = fix_r[0];
  assign nu  = fix_r[1];
  assign nv  = fix_r[2];
  assign nt  = fix_r[3];

endmodule

// ----- hw/rtl/rth_judge.sv -----
// range checks against det and the registered result, two stages
module rth_judge
  import rth_pkg::*;
#(
  parameter int CW = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   d_valid,
  output logic                   d_ready,
  input  logic signed [3*CW+5:0] det,
  input  logic signed [3*CW+5:0] nu,
  input  logic signed [3*CW+5:0] nv,
  input  logic signed [3*CW+5:0] nt,
  input  logic [THR_WIDTH-1:0]   thr,
  rth_out_if.source              out_res
);

  localparam int DOTW = 3 * CW + 6;

  logic en_j, en_o;
  logic vj_r, vo_r;

  logic signed [DOTW-1:0] thr_ext;
  logic                   small_nxt, ubad_nxt, vneg_nxt, tbad_nxt;
  logic                   small_r, ubad_r, vneg_r, tbad_r;
  logic signed [DOTW-1:0] uv_nxt;
  logic signed [DOTW-1:0] uv_r;
  logic signed [DOTW-1:0] detj_r;
  reason_t                reason_nxt;
  reason_t                reason_r;

  assign en_o    = ~vo_r | out_res.ready;
  assign en_j    = ~vj_r | en_o;
  assign d_ready = en_j;

  assign thr_ext = DOTW'(thr);

  always_comb begin
    small_nxt = (det == '0) || (thr_ext > det);
    ubad_nxt  = nu[DOTW-1] || (nu > det);
    vneg_nxt  = nv[DOTW-1];
    tbad_nxt  = nt[DOTW-1] || (nt == '0);
    uv_nxt    = nu + nv;
  end

  // first failing check names the reason
  always_comb begin
    if (small_r) begin
      reason_nxt = REASON_PARALLEL;
    end else if (ubad_r) begin
      reason_nxt = REASON_U_OUT;
    end else if (vneg_r || (uv_r > detj_r)) begin
      reason_nxt = REASON_V_OUT;
    end else if (tbad_r) begin
      reason_nxt = REASON_BEHIND;
    end else begin
      reason_nxt = REASON_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vj_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en_j) vj_r <= d_valid;
      if (en_o) vo_r <= vj_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_j) begin
      small_r <= small_nxt;
      ubad_r  <= ubad_nxt;
      vneg_r  <= vneg_nxt;
      tbad_r  <= tbad_nxt;
      uv_r    <= uv_nxt;
      detj_r  <= det;
    end
    if (en_o) reason_r <= reason_nxt;
  end

  assign out_res.valid         = vo_r;
  assign out_res.hit           = (reason_r == REASON_HIT);
  assign out_res.reject_reason = reason_r;

endmodule

// ----- hw/rtl/ray_triangle_hit_test_top.sv -----
// Moller-Trumbore ray-triangle hit test: one triangle in and one result out
// per clock against a configured ray while out_res.ready is high. Triangles
// pass rth_geom (edges and cross products), rth_dot (split-operand dot
// products, sign fix of det) and rth_judge (range checks, output register);
// each stage holds its own valid bit, so bubbles close up under back-pressure
// and a full pipeline holds 10 triangles. The user must write ray origin,
// direction and the det threshold through the cfg port only while no
// triangle is in flight; the block itself does not enforce it.
module ray_triangle_hit_test_top
  import rth_pkg::*;
#(
  parameter int COORD_WIDTH = 20,
  parameter int FRAC_BITS   = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rth_in_if.sink               in_tri,
  rth_out_if.source            out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_WIDTH-1:0] cfg_wdata
);

  localparam int CW   = COORD_WIDTH;
  localparam int DOTW = 3 * CW + 6;

  logic signed [CW-1:0]  origin_r [3];
  logic signed [CW-1:0]  dir_r [3];
  logic [THR_WIDTH-1:0]  thr_r;

  logic                  g_valid, g_ready;
  logic signed [CW:0]    e1 [3];
  logic signed [CW:0]    e2 [3];
  logic signed [CW:0]    s [3];
  logic signed [2*CW+2:0] p [3];
  logic signed [2*CW+2:0] q [3];

  logic                  d_valid, d_ready;
  logic signed [DOTW-1:0] det, nu, nv, nt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '{default: '0};
      dir_r    <= '{CW'(1) << FRAC_BITS, '0, '0};
      thr_r    <= DET_THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: origin_r[0] <= cfg_wdata[CW-1:0];
        CFG_ORIGIN_Y: origin_r[1] <= cfg_wdata[CW-1:0];
        CFG_ORIGIN_Z: origin_r[2] <= cfg_wdata[CW-1:0];
        CFG_DIR_X:    dir_r[0]    <= cfg_wdata[CW-1:0];
        CFG_DIR_Y:    dir_r[1]    <= cfg_wdata[CW-1:0];
        CFG_DIR_Z:    dir_r[2]    <= cfg_wdata[CW-1:0];
        CFG_DET_THR:  thr_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rth_geom #(.CW(CW)) u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tri  (in_tri),
    .origin  (origin_r),
    .dir     (dir_r),
    .g_valid (g_valid),
    .g_ready (g_ready),
    .e1      (e1),
    .e2      (e2),
    .s       (s),
    .p       (p),
    .q       (q)
  );

  rth_dot #(.CW(CW)) u_dot (
    .clk     (clk),
    .rst_n   (rst_n),
    .g_valid (g_valid),
    .g_ready (g_ready),
    .dir     (dir_r),
    .e1      (e1),
    .e2      (e2),
    .s       (s),
    .p       (p),
    .q       (q),
    .d_valid (d_valid),
    .d_ready (d_ready),
    .det     (det),
    .nu      (nu),
    .nv      (nv),
    .nt      (nt)
  );

  rth_judge #(.CW(CW)) u_judge (
    .clk     (clk),
    .rst_n   (rst_n),
    .d_valid (d_valid),
    .d_ready (d_ready),
    .det     (det),
    .nu      (nu),
    .nv      (nv),
    .nt      (nt),
    .thr     (thr_r),
    .out_res (out_res)
  );

`ifndef SYNTH
  // hit flag and reason must agree
  a_hit_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.hit == (out_res.reject_reason == REASON_HIT)))
    else $error("hit flag disagrees with reject reason");

  a_reason_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.reject_reason <= REASON_BEHIND))
    else $error("reject reason out of range");

  // a free output side lets every stage move, so input must be open
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.ready |-> in_tri.ready)
    else $error("input stalled while output is ready");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_res.valid)
    else $error("result valid right after reset");
`endif

endmodule

// ----- tb/rth_hit_checker.sv -----
// hit-test checker: predicts each triangle's result from the ray setup and compares
module rth_hit_checker
  import rth_pkg::*;
#(
  parameter int COORD_WIDTH = 20,
  parameter int FRAC_BITS   = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rth_in_if                    tri_mon,
  rth_out_if                   res_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_WIDTH-1:0] cfg_wdata,
  output int                   fail_count,
  output int                   n_pending,
  output int                   n_results,
  output int                   n_hits,
  output logic [4:0]           reasons_seen
);

  typedef logic signed [127:0]            wide_t;
  typedef logic signed [COORD_WIDTH-1:0]  coord_t;
  typedef struct packed {
    logic    hit;
    reason_t reason;
  } verdict_t;

  coord_t                ray_org [3];
  coord_t                ray_dir [3];
  logic [THR_WIDTH-1:0]  det_thr;
  verdict_t              verdict_q [$];
  verdict_t              want;
  coord_t                v1 [3];
  coord_t                v2 [3];
  coord_t                v3 [3];

  // exact moller-trumbore: divisions by det turned into comparisons
  function automatic verdict_t classify(input coord_t a[3], input coord_t b[3],
                                        input coord_t c[3]);
    wide_t    e1 [3];
    wide_t    e2 [3];
    wide_t    s  [3];
    wide_t    d  [3];
    wide_t    p  [3];
    wide_t    q  [3];
    wide_t    det, nu, nv, nt, thr;
    verdict_t r;
    int       i;
    for (i = 0; i < 3; i++) begin
      e1[i] = wide_t'(b[i]) - wide_t'(a[i]);
      e2[i] = wide_t'(c[i]) - wide_t'(a[i]);
      s[i]  = wide_t'(ray_org[i]) - wide_t'(a[i]);
      d[i]  = wide_t'(ray_dir[i]);
    end
    p[0] = d[1] * e2[2] - d[2] * e2[1];
    p[1] = d[2] * e2[0] - d[0] * e2[2];
    p[2] = d[0] * e2[1] - d[1] * e2[0];
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
    nu  = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
    nv  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    nt  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    // sign-correct so all comparisons run against a positive det
    if (det < 0) begin
      det = -det;
      nu  = -nu;
      nv  = -nv;
      nt  = -nt;
    end
    thr = wide_t'({1'b0, det_thr});
    if (det == 0 || thr > det) begin
      r.reason = REASON_PARALLEL;
    end else if (nu < 0 || nu > det) begin
      r.reason = REASON_U_OUT;
    end else if (nv < 0 || nu + nv > det) begin
      r.reason = REASON_V_OUT;
    end else if (nt <= 0) begin
      r.reason = REASON_BEHIND;
    end else begin
      r.reason = REASON_HIT;
    end
    r.hit = (r.reason == REASON_HIT);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ray_org[0] = '0;
      ray_org[1] = '0;
      ray_org[2] = '0;
      ray_dir[0] = COORD_WIDTH'(1 << FRAC_BITS);
      ray_dir[1] = '0;
      ray_dir[2] = '0;
      det_thr    = DET_THR_RESET;
      verdict_q.delete();
      reasons_seen = '0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (verdict_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("hit test: result transaction with nothing outstanding (hit=%0b reason=%0d)",
                     res_mon.hit, res_mon.reject_reason);
          end
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (res_mon.hit !== want.hit || res_mon.reject_reason !== want.reason) begin
            if (fail_count < 10) begin
              $display("mismatch %0d: expected hit=%0b reason=%0d, got hit=%0b reason=%0d",
                       n_results, want.hit, want.reason, res_mon.hit, res_mon.reject_reason);
            end
            fail_count++;
          end
        end
        if (res_mon.hit === 1'b1) n_hits++;
        if (res_mon.reject_reason <= REASON_BEHIND) reasons_seen[res_mon.reject_reason] = 1'b1;
        n_results++;
      end
      if (tri_mon.valid && tri_mon.ready) begin
        v1 = '{tri_mon.first_x, tri_mon.first_y, tri_mon.first_z};
        v2 = '{tri_mon.second_x, tri_mon.second_y, tri_mon.second_z};
        v3 = '{tri_mon.third_x, tri_mon.third_y, tri_mon.third_z};
        verdict_q.insert(verdict_q.size(), classify(v1, v2, v3));
      end
      // register writes land after this edge's prediction
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORIGIN_X: ray_org[0] = cfg_wdata[COORD_WIDTH-1:0];
          CFG_ORIGIN_Y: ray_org[1] = cfg_wdata[COORD_WIDTH-1:0];
          CFG_ORIGIN_Z: ray_org[2] = cfg_wdata[COORD_WIDTH-1:0];
          CFG_DIR_X:    ray_dir[0] = cfg_wdata[COORD_WIDTH-1:0];
          CFG_DIR_Y:    ray_dir[1] = cfg_wdata[COORD_WIDTH-1:0];
          CFG_DIR_Z:    ray_dir[2] = cfg_wdata[COORD_WIDTH-1:0];
          CFG_DET_THR:  det_thr    = cfg_wdata;
          default: ;
        endcase
      end
    end
    n_pending = verdict_q.size();
  end

endmodule

// ----- tb/tb_ray_triangle_hit_test_top.sv -----
// testbench top: drives triangles and ray setups into the hit test and reports the verdict
module tb_ray_triangle_hit_test_top;
  import rth_pkg::*;

  localparam int CW             = 20;
  localparam int FB             = 10;
  localparam int U              = 1 << FB;
  localparam int CMAX           = (1 << (CW - 1)) - 1;
  localparam int CMIN           = -(1 << (CW - 1));
  localparam int PIPE_LATENCY   = 10;
  localparam int HOLD_CYCLES    = 250;
  localparam int PHASE_ITEMS    = 150;
  localparam int N_PHASES       = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [THR_WIDTH-1:0] THR_MAX = {1'b1, {(THR_WIDTH - 1){1'b0}}};

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [THR_WIDTH-1:0] cfg_wdata;

  rth_in_if #(.COORD_WIDTH(CW)) in_tri ();
  rth_out_if                    out_res ();

  int         fail_count;
  int         n_pending;
  int         n_results;
  int         n_hits;
  logic [4:0] reasons_seen;
  int         n_settings;
  int         ray_o [3];
  int         ray_d [3];

  // window where neither side idles
  wire steady = (n_results >= 700) && (n_results < 900);

  always #5 clk = ~clk;

  ray_triangle_hit_test_top #(
    .COORD_WIDTH (CW),
    .FRAC_BITS   (FB)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tri    (in_tri),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rth_hit_checker #(
    .COORD_WIDTH (CW),
    .FRAC_BITS   (FB)
  ) u_hit_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .tri_mon      (in_tri),
    .res_mon      (out_res),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .n_pending    (n_pending),
    .n_results    (n_results),
    .n_hits       (n_hits),
    .reasons_seen (reasons_seen)
  );

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int to_coord(input int c);
    logic signed [CW-1:0] w;
    w = CW'(c);
    return int'(w);
  endfunction

  // upper bits carry noise that the coordinate registers must drop
  function automatic logic [THR_WIDTH-1:0] coord_word(input int c);
    return {(THR_WIDTH - CW)'($urandom), CW'(c)};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_WIDTH-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic set_ray(input int ox, input int oy, input int oz, input int dx, input int dy,
                         input int dz, input logic [THR_WIDTH-1:0] thr);
    write_reg(CFG_ORIGIN_X, coord_word(ox));
    write_reg(CFG_ORIGIN_Y, coord_word(oy));
    write_reg(CFG_ORIGIN_Z, coord_word(oz));
    write_reg(CFG_DIR_X, coord_word(dx));
    write_reg(CFG_DIR_Y, coord_word(dy));
    write_reg(CFG_DIR_Z, coord_word(dz));
    write_reg(CFG_DET_THR, thr);
    cfg_we <= 1'b0;
    ray_o = '{to_coord(ox), to_coord(oy), to_coord(oz)};
    ray_d = '{to_coord(dx), to_coord(dy), to_coord(dz)};
    n_settings++;
  endtask

  task automatic send_tri(input int vtx[9]);
    while (!steady && $urandom_range(99) < 9) begin
      in_tri.valid <= 1'b0;
      @(negedge clk);
    end
    in_tri.first_x  <= CW'(vtx[0]);
    in_tri.first_y  <= CW'(vtx[1]);
    in_tri.first_z  <= CW'(vtx[2]);
    in_tri.second_x <= CW'(vtx[3]);
    in_tri.second_y <= CW'(vtx[4]);
    in_tri.second_z <= CW'(vtx[5]);
    in_tri.third_x  <= CW'(vtx[6]);
    in_tri.third_y  <= CW'(vtx[7]);
    in_tri.third_z  <= CW'(vtx[8]);
    in_tri.valid    <= 1'b1;
    @(posedge clk);
    while (!in_tri.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send9(input int a0, input int a1, input int a2, input int a3, input int a4,
                       input int a5, input int a6, input int a7, input int a8);
    int vtx [9];
    vtx = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
    send_tri(vtx);
  endtask

  task automatic make_tri(output int vtx[9]);
    int hitp [3];
    int e1 [3];
    int e2 [3];
    int sel, t, span, k1, k2, i;
    sel  = $urandom_range(99);
    t    = pick(-3, 12);
    span = ($urandom_range(9) == 0) ? pick(1, 3) : pick(16, 1024);
    k1   = pick(-1, 4);
    k2   = pick(-1, 4);
    for (i = 0; i < 3; i++) begin
      hitp[i] = ray_o[i] + t * ray_d[i];
      e1[i]   = 4 * pick(-span, span);
      e2[i]   = 4 * pick(-span, span);
    end
    for (i = 0; i < 3; i++) begin
      if (sel < 55) begin
        // ray crosses the plane at barycentric (k1/4, k2/4), boundaries included
        vtx[i]     = hitp[i] - (k1 * e1[i] + k2 * e2[i]) / 4;
        vtx[3 + i] = vtx[i] + e1[i];
        vtx[6 + i] = vtx[i] + e2[i];
      end else if (sel < 70) begin
        vtx[i]     = hitp[i] + pick(-4 * span, 4 * span);
        vtx[3 + i] = hitp[i] + pick(-4 * span, 4 * span);
        vtx[6 + i] = hitp[i] + pick(-4 * span, 4 * span);
      end else if (sel < 80) begin
        // collinear or repeated vertex, det is zero
        vtx[i]     = hitp[i] + e2[i];
        vtx[3 + i] = vtx[i] + e1[i];
        vtx[6 + i] = (sel < 75) ? vtx[i] + 2 * e1[i] : vtx[3 + i];
      end else begin
        vtx[i]     = $urandom;
        vtx[3 + i] = $urandom;
        vtx[6 + i] = $urandom;
      end
    end
  endtask

  task automatic wait_drain();
    in_tri.valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
  endtask

  // result side: random stalls, one long hold-off to back the pipeline up
  initial begin : receiver
    int   hold_left;
    logic held;
    logic rdy;
    out_res.ready = 1'b0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end else if (!held && n_results >= 400) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rdy = 1'b0;
      end else if (steady) begin
        rdy = 1'b1;
      end else begin
        rdy = ($urandom_range(99) >= 9);
      end
      out_res.ready <= rdy;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tri.valid && in_tri.ready) || (out_res.valid && out_res.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_ray_triangle_hit_test_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    int                   vtx [9];
    int                   ph, k;
    logic [THR_WIDTH-1:0] thr;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_tri.valid    = 1'b0;
    in_tri.first_x  = '0;
    in_tri.first_y  = '0;
    in_tri.first_z  = '0;
    in_tri.second_x = '0;
    in_tri.second_y = '0;
    in_tri.second_z = '0;
    in_tri.third_x  = '0;
    in_tri.third_y  = '0;
    in_tri.third_z  = '0;
    n_settings      = 0;
    ray_o           = '{0, 0, 0};
    ray_d           = '{U, 0, 0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset ray: origin at zero looking down +x, threshold 1074
    send9(5*U, -U, -U, 5*U, 2*U, -U, 5*U, -U, 2*U);
    send9(5*U, -U, -U, 5*U, -U, 2*U, 5*U, 2*U, -U);
    send9(-5*U, -U, -U, -5*U, 2*U, -U, -5*U, -U, 2*U);
    send9(0, -U, -U, 0, 2*U, -U, 0, -U, 2*U);
    send9(0, 0, U, U, 0, U, 0, U, U);
    send9(5*U, U, -U, 5*U, 3*U, -U, 5*U, U, 2*U);
    send9(5*U, -3*U, -U, 5*U, -U, -U, 5*U, -3*U, 2*U);
    send9(5*U, -U, U, 5*U, 2*U, U, 5*U, -U, 3*U);
    send9(5*U, -U, -U, 5*U, 0, -U, 5*U, -U, 0);
    send9(5*U, 0, -U, 5*U, 2*U, -U, 5*U, 0, 2*U);
    send9(5*U, -U, 0, 5*U, 0, 0, 5*U, -U, U);
    send9(5*U, -U, -U, 5*U, U, -U, 5*U, -U, U);
    send9(5*U, 0, 0, 5*U, 1, 0, 5*U, 0, 1);
    send9(5*U, 0, 0, 5*U, 2, 0, 5*U, 0, 1);
    send9(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    send9(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send9(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX);
    send9(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN);
    send9('h55555, 'haaaaa, 'h55555, 'haaaaa, 'h55555, 'haaaaa, 'h55555, 'haaaaa, 'h55555);
    wait_drain();

    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: set_ray(0, 0, 0, U, 0, 0, THR_WIDTH'(2048));
        1: set_ray(1536, -2304, 512, 512, 1024, -768, DET_THR_RESET);
        2: set_ray(pick(-8192, 8192), pick(-8192, 8192), pick(-8192, 8192),
                   pick(-2048, 2048), pick(-2048, 2048), pick(-2048, 2048),
                   THR_WIDTH'($urandom_range(1 << 20)));
        3: set_ray(pick(-8192, 8192), pick(-8192, 8192), pick(-8192, 8192),
                   pick(-2048, 2048), pick(-2048, 2048), pick(-2048, 2048), '0);
        4: set_ray(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, THR_MAX);
        5: begin
          thr = {1'b0, (THR_WIDTH - 1)'({$urandom, $urandom})};
          set_ray(CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, thr);
        end
        6: set_ray(pick(-8192, 8192), pick(-8192, 8192), pick(-8192, 8192),
                   pick(-3, 3), pick(-3, 3), pick(-3, 3), DET_THR_RESET);
        default: set_ray(pick(-8192, 8192), pick(-8192, 8192), pick(-8192, 8192),
                         pick(-2048, 2048), pick(-2048, 2048), pick(-2048, 2048),
                         THR_WIDTH'(pick(0, 4096)));
      endcase
      if (ph == 0) begin
        // |det| at half the threshold and exactly at the threshold
        send9(5*U, 0, 0, 5*U, 1, 0, 5*U, 0, 1);
        send9(5*U, 0, 0, 5*U, 2, 0, 5*U, 0, 1);
      end else if (ph == 3) begin
        // zero det must still be parallel with a zero threshold
        send9(0, 0, 0, U, U, U, 2*U, 2*U, 2*U);
        send9(U, 2*U, 3*U, U, 2*U, 3*U, -U, 0, U);
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        make_tri(vtx);
        send_tri(vtx);
      end
      wait_drain();
    end

    repeat (PIPE_LATENCY + 2) @(negedge clk);
    $display("tb: %0d triangle results checked under %0d ray setups, %0d of them hits",
             n_results, n_settings + 1, n_hits);
    $display("tb: reject reasons observed (bit 0 hit .. bit 4 behind origin): %b", reasons_seen);
    if (fail_count == 0 && n_pending == 0) begin
      $display("tb_ray_triangle_hit_test_top: done, clean");
    end else begin
      $display("tb_ray_triangle_hit_test_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rth_pkg.sv
hw/rtl/rth_if.sv
hw/rtl/rth_geom.sv
hw/rtl/rth_dot.sv
hw/rtl/rth_judge.sv
hw/rtl/ray_triangle_hit_test_top.sv
tb/rth_hit_checker.sv
tb/tb_ray_triangle_hit_test_top.sv
